// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_unit and the testbench; depends on nothing.

package spq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_WIDTH          = 32;
   localparam int unsigned PRIO_WIDTH           = 16;
   localparam int unsigned COUNT_OUT_WIDTH      = 5;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic        [PRIO_WIDTH-1:0]  prio;
   } entry_type;

   // Command broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cmd_type;

endpackage

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue, top level: a chain of spq_cell slots plus count and result register.
// Depends on spq_pkg and spq_cell.
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle unless rsp_stall holds the result; cells update in parallel.
// Reset (synchronous, active high) clears the entry count and the result valid flag.
// Slot contents are not reset; only slots below the entry count are ever read.

module sorted_priority_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] req_entry_value,
   input  logic [spq_pkg::PRIO_WIDTH-1:0]         req_entry_priority,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_removed_value,
   output logic [spq_pkg::PRIO_WIDTH-1:0]         rsp_removed_priority,
   output logic [spq_pkg::COUNT_OUT_WIDTH-1:0]    rsp_entry_count
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   // Entry count and result register.
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::status_type status_ff;
   spq_pkg::status_type status_in;
   spq_pkg::entry_type removed_ff;
   spq_pkg::entry_type removed_in;
   logic [spq_pkg::COUNT_OUT_WIDTH-1:0] rsp_count_ff;
   logic [spq_pkg::COUNT_OUT_WIDTH-1:0] rsp_count_in;

   logic accept;
   logic full;
   logic empty;
   spq_pkg::cmd_type cmd;

   logic               occupied [QUEUE_DEPTH];
   logic               ge       [QUEUE_DEPTH];
   spq_pkg::entry_type slot     [QUEUE_DEPTH];

   // The result register is the only buffer: a new item is taken whenever the
   // pending result is gone or is being taken in this same cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.insert      = accept && (req_kind == spq_pkg::KIND_ENQUEUE) && !full;
      cmd.remove      = accept && (req_kind == spq_pkg::KIND_DEQUEUE) && !empty;
      cmd.entry.value = req_entry_value;
      cmd.entry.prio  = req_entry_priority;
   end

   // The chain. Each cell compares its own priority with the incoming one; since
   // the chain is sorted, the compare results form a prefix, and the first cell
   // whose compare fails takes the new entry while the rest shift right by one.
   // On a dequeue every cell takes its right neighbor's entry.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_ge;

      assign occupied[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign left_ge    = 1'b1;
         assign left_entry = slot[i];
      end else begin : g_inner
         assign left_ge    = ge[i-1];
         assign left_entry = slot[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = slot[i];
      end else begin : g_mid
         assign right_entry = slot[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied[i]),
         .left_ge     (left_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ge          (ge[i]),
         .entry       (slot[i])
      );
   end

   // Count update and result formation for the accepted item.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_count_in = rsp_count_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         removed_in   = '0;
         if (req_kind == spq_pkg::KIND_ENQUEUE) begin
            if (full) begin
               status_in = spq_pkg::STATUS_FULL;
            end else begin
               status_in = spq_pkg::STATUS_DONE;
               count_in  = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status_in = spq_pkg::STATUS_EMPTY;
            end else begin
               status_in  = spq_pkg::STATUS_DONE;
               removed_in = slot[0];
               count_in   = count_ff - CW'(1);
            end
         end
         rsp_count_in = spq_pkg::COUNT_OUT_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_removed_value    = removed_ff.value;
   assign rsp_removed_priority = removed_ff.prio;
   assign rsp_entry_count      = rsp_count_ff;

   // The count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   // The head two slots are in descending priority order whenever both hold entries.
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      occupied[1] |-> (slot[0].prio >= slot[1].prio))
      else $error("head slots out of priority order");

   // A rejected enqueue reports the full count.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == spq_pkg::STATUS_FULL)
         |-> (rsp_entry_count == spq_pkg::COUNT_OUT_WIDTH'(QUEUE_DEPTH)))
      else $error("full status with wrong count");

   // Only a successful dequeue returns a nonzero removed entry.
   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != spq_pkg::STATUS_DONE)
         |-> (rsp_removed_value == '0 && rsp_removed_priority == '0))
      else $error("removed fields nonzero on a failed item");

   // A stalled item leaves the count unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (req_stall) |=> $stable(count_ff))
      else $error("count changed while input stalled");

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and command types.

module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  logic               left_ge,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               ge,
   output spq_pkg::entry_type entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // The stored entry stays ahead of the new one when its priority is not lower.
   assign ge = occupied && (entry_ff.prio >= cmd.entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!ge) begin
            entry_in = left_ge ? cmd.entry : left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sim/tb_sorted_priority_queue_unit.sv =====
// Self-checking testbench for sorted_priority_queue_unit: directed table, then random traffic.
// Depends on spq_pkg and the RTL of the queue; expected results come from an in-bench predictor.

module tb_sorted_priority_queue_unit;

   localparam int unsigned DEPTH       = spq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int          RANDOM_ITEMS = 875;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          IDLE_PCT     = 11;
   localparam int          MAX_PRINTS   = 100;

   // One result item as the block presents it.
   typedef struct packed {
      spq_pkg::status_type                 status;
      logic signed [31:0]                  value;
      logic [spq_pkg::PRIO_WIDTH-1:0]      prio;
      logic [spq_pkg::COUNT_OUT_WIDTH-1:0] count;
   } queue_result_type;

   // One row of the directed table. A row with a typed result is checked against
   // that result directly; the other rows are checked against the predictor.
   typedef struct {
      logic                           kind;
      logic signed [31:0]             value;
      logic [spq_pkg::PRIO_WIDTH-1:0] prio;
      bit                             typed;
      queue_result_type               result;
   } stim_row_type;

   // A typed expectation, or a marker that the predictor decides.
   typedef struct {
      bit               typed;
      queue_result_type result;
   } typed_result_type;

   logic                                   clock;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic                                   req_kind = spq_pkg::KIND_ENQUEUE;
   logic signed [spq_pkg::VALUE_WIDTH-1:0] req_entry_value = '0;
   logic [spq_pkg::PRIO_WIDTH-1:0]         req_entry_priority = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [1:0]                             rsp_status;
   logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_removed_value;
   logic [spq_pkg::PRIO_WIDTH-1:0]         rsp_removed_priority;
   logic [spq_pkg::COUNT_OUT_WIDTH-1:0]    rsp_entry_count;

   sorted_priority_queue_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_entry_value     (req_entry_value),
      .req_entry_priority  (req_entry_priority),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_removed_value   (rsp_removed_value),
      .rsp_removed_priority(rsp_removed_priority),
      .rsp_entry_count     (rsp_entry_count)
   );

   // Shadow copy of the queue contents. Slot 0 is the head; the slots are kept
   // sorted by descending priority, ties in arrival order.
   logic signed [31:0]             held_values [DEPTH];
   logic [spq_pkg::PRIO_WIDTH-1:0] held_prios  [DEPTH];
   int                             held_count = 0;

   queue_result_type pending_results[$];
   typed_result_type typed_results[$];
   stim_row_type     directed_rows[$];
   queue_result_type oldest_result;
   queue_result_type predicted_result;
   typed_result_type typed_entry;

   int idle_pct       = IDLE_PCT;
   int mismatch_count = 0;
   int checked_items  = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic queue_result_type make_result(input spq_pkg::status_type status,
                                                    input logic signed [31:0] value,
                                                    input logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                                                    input int count);
      queue_result_type r;
      r.status = status;
      r.value  = value;
      r.prio   = prio;
      r.count  = count[spq_pkg::COUNT_OUT_WIDTH-1:0];
      return r;
   endfunction

   // Applies one accepted item to the shadow queue and returns the result the
   // block must give for it.
   function automatic queue_result_type apply_queue_item(
      input logic kind,
      input logic signed [31:0] value,
      input logic [spq_pkg::PRIO_WIDTH-1:0] prio);
      int                             slot;
      int                             i;
      logic signed [31:0]             head_value;
      logic [spq_pkg::PRIO_WIDTH-1:0] head_prio;
      if (kind == spq_pkg::KIND_ENQUEUE) begin
         // A full queue rejects the entry and stays as it is.
         if (held_count >= DEPTH) begin
            return make_result(spq_pkg::STATUS_FULL, '0, '0, held_count);
         end
         // Walk past every entry of higher or equal priority, so the new entry
         // lands behind its equals.
         slot = 0;
         while (slot < held_count && held_prios[slot] >= prio) slot++;
         for (i = held_count; i > slot; i--) begin
            held_values[i] = held_values[i-1];
            held_prios[i]  = held_prios[i-1];
         end
         held_values[slot] = value;
         held_prios[slot]  = prio;
         held_count++;
         return make_result(spq_pkg::STATUS_DONE, '0, '0, held_count);
      end
      if (held_count == 0) begin
         return make_result(spq_pkg::STATUS_EMPTY, '0, '0, 0);
      end
      head_value = held_values[0];
      head_prio  = held_prios[0];
      for (i = 1; i < held_count; i++) begin
         held_values[i-1] = held_values[i];
         held_prios[i-1]  = held_prios[i];
      end
      held_count--;
      return make_result(spq_pkg::STATUS_DONE, head_value, head_prio, held_count);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("mismatch at result %0d, %s: got %0h, expected %0h",
                  checked_items, field, got, want);
      end
   endtask

   task automatic add_row(input logic kind, input logic signed [31:0] value,
                          input logic [spq_pkg::PRIO_WIDTH-1:0] prio, input bit typed,
                          input queue_result_type result);
      stim_row_type row;
      row.kind   = kind;
      row.value  = value;
      row.prio   = prio;
      row.typed  = typed;
      row.result = result;
      directed_rows.push_back(row);
   endtask

   // Presents one item and returns once the block has taken it. Random idle
   // cycles go in front of the item; valid is only lowered in those cycles.
   task automatic send_item(input logic kind, input logic signed [31:0] value,
                            input logic [spq_pkg::PRIO_WIDTH-1:0] prio, input bit typed,
                            input queue_result_type result);
      typed_result_type t;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      t.typed  = typed;
      t.result = result;
      typed_results.push_back(t);
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_entry_value    <= value;
      req_entry_priority <= prio;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Priorities lean toward a few small values so that ties are common, with
   // the extremes and the full range mixed in.
   function automatic logic [spq_pkg::PRIO_WIDTH-1:0] pick_prio();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return spq_pkg::PRIO_WIDTH'($urandom_range(3));
      if (roll < 60) return '0;
      if (roll < 70) return '1;
      return spq_pkg::PRIO_WIDTH'($urandom_range(65535));
   endfunction

   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 32'sh7FFFFFFF;
      if (roll < 10) return 32'sh80000000;
      return $urandom;
   endfunction

   // The request-side monitor: every accepted item runs through the predictor
   // so the shadow queue tracks the block, and the typed expectation, where
   // the row has one, takes the place of the predicted one.
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0) begin
         predicted_result = apply_queue_item(req_kind, req_entry_value, req_entry_priority);
         typed_entry      = typed_results.pop_front();
         pending_results.push_back(typed_entry.typed ? typed_entry.result : predicted_result);
      end
   end

   // The receiver stalls at random, except while idling is switched off.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Each accepted result is compared with the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", 32'(rsp_valid), 32'd0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_status !== oldest_result.status)
               report_mismatch("status", 32'(rsp_status), 32'(oldest_result.status));
            if (rsp_removed_value !== oldest_result.value)
               report_mismatch("removed_value", rsp_removed_value, oldest_result.value);
            if (rsp_removed_priority !== oldest_result.prio)
               report_mismatch("removed_priority", 32'(rsp_removed_priority),
                               32'(oldest_result.prio));
            if (rsp_entry_count !== oldest_result.count)
               report_mismatch("entry_count", 32'(rsp_entry_count), 32'(oldest_result.count));
         end
         checked_items++;
      end
   end

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      queue_result_type none;
      int               i;
      int               phase;
      int               enq_pct;
      logic             kind;
      none = make_result(spq_pkg::STATUS_DONE, '0, '0, 0);

      // Directed part. An empty queue answers a dequeue with the empty status.
      add_row(spq_pkg::KIND_DEQUEUE, 32'sd0, 16'd0, 1'b1,
              make_result(spq_pkg::STATUS_EMPTY, '0, '0, 0));
      // The extreme value and priority go in and come back out in priority order.
      add_row(spq_pkg::KIND_ENQUEUE, 32'sh80000000, 16'h0000, 1'b1,
              make_result(spq_pkg::STATUS_DONE, '0, '0, 1));
      add_row(spq_pkg::KIND_ENQUEUE, 32'sh7FFFFFFF, 16'hFFFF, 1'b1,
              make_result(spq_pkg::STATUS_DONE, '0, '0, 2));
      add_row(spq_pkg::KIND_DEQUEUE, 32'sd0, 16'd0, 1'b1,
              make_result(spq_pkg::STATUS_DONE, 32'sh7FFFFFFF, 16'hFFFF, 1));
      add_row(spq_pkg::KIND_DEQUEUE, 32'sd0, 16'd0, 1'b1,
              make_result(spq_pkg::STATUS_DONE, 32'sh80000000, 16'h0000, 0));
      add_row(spq_pkg::KIND_DEQUEUE, 32'sd0, 16'd0, 1'b1,
              make_result(spq_pkg::STATUS_EMPTY, '0, '0, 0));
      // Fill the queue with a mix of tied and distinct priorities.
      for (i = 0; i < DEPTH; i++) begin
         add_row(spq_pkg::KIND_ENQUEUE, {i[0], 31'(i * 1001 + 7)},
                 (i % 3 == 0) ? 16'd7 : spq_pkg::PRIO_WIDTH'(i % 5), 1'b0, none);
      end
      // A full queue rejects the entry and keeps its count.
      add_row(spq_pkg::KIND_ENQUEUE, 32'sh7FFFFFFF, 16'hFFFF, 1'b1,
              make_result(spq_pkg::STATUS_FULL, '0, '0, DEPTH));
      add_row(spq_pkg::KIND_DEQUEUE, 32'sd0, 16'd0, 1'b0, none);
      add_row(spq_pkg::KIND_ENQUEUE, 32'sh12345678, 16'd7, 1'b0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].kind, directed_rows[r].value, directed_rows[r].prio,
                   directed_rows[r].typed, directed_rows[r].result);
      end

      // Random part. Phases of 50 items alternate between filling, draining and
      // balanced traffic so that the queue swings between full and empty.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         phase   = (i / 50) % 3;
         enq_pct = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
         // A long stretch runs with neither side idling.
         idle_pct = (i >= 300 && i < 450) ? 0 : IDLE_PCT;
         kind = ($urandom_range(99) < enq_pct) ? spq_pkg::KIND_ENQUEUE
                                                : spq_pkg::KIND_DEQUEUE;
         send_item(kind, pick_value(), pick_prio(), 1'b0, none);
      end

      req_valid <= 1'b0;
      idle_pct = IDLE_PCT;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_queue_unit.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
sim/tb_sorted_priority_queue_unit.sv
